// ----- design/xor_trie_kth_largest_macros.svh -----
// ----------------------------------------------------------------------------
// XOR trie assertion macros
// Shared concurrent assertion forms for the XOR trie block.
// ----------------------------------------------------------------------------
`ifndef XOR_TRIE_KTH_LARGEST_MACROS_SVH
`define XOR_TRIE_KTH_LARGEST_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define XTKL_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define XTKL_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/xtkl_pkg.sv -----
// ----------------------------------------------------------------------------
// XOR trie package
// Beat types, state encoding and fixed constants of the XOR trie block.
// ----------------------------------------------------------------------------
package xtkl_pkg;

  localparam int KEY_BITS = 32;
  localparam int LVL_W    = $clog2(KEY_BITS);
  localparam int SIZE_W   = 16;

  localparam logic [SIZE_W-1:0] KEYS_MAX = '1;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_RANK = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [KEY_BITS-1:0] key;
    logic [SIZE_W-1:0]   rank;
  } req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] xor_value;
    logic [1:0]          status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_FIN,
    ST_QRY,
    ST_RESP
  } state_e;

endpackage

// ----- design/xor_trie_kth_largest.sv -----
// ----------------------------------------------------------------------------
// XOR trie k-th largest
// Binary trie over 32-bit keys with insert and k-th largest XOR query.
// ----------------------------------------------------------------------------
// An insert reads and writes one node record per key bit, and a query reads
// both child records of its current node per key bit; a refused request skips the walk.
// One request at a time: a new request is taken only in idle, after the walk over
// the 32 key bits through the node memory and the result hand-off are done.
// Reset clears the counters and root links at once; node records need no
// clearing pass because each one is written when it is allocated.
module xor_trie_kth_largest
  import xtkl_pkg::*;
#(
  parameter int NODE_COUNT = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

`include "xor_trie_kth_largest_macros.svh"

  localparam int NW = $clog2(NODE_COUNT);
  localparam int WW = SIZE_W + 2 * NW;
  localparam logic [NW-1:0] NODE_LIMIT = NW'(NODE_COUNT - 1 - KEY_BITS);
  localparam logic [NW-1:0] NODE_MAX   = NW'(NODE_COUNT - 1);

  state_e state_q, state_d;

  logic [LVL_W-1:0]    lvl_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SIZE_W-1:0]   rank_q;
  logic [KEY_BITS-1:0] acc_q;
  logic [1:0]          status_q;
  logic [NW-1:0]       cur_q;
  logic                at_root_q;
  logic                fresh_q;
  logic [NW-1:0]       nodes_used_q;
  logic [SIZE_W-1:0]   keys_stored_q;
  logic [NW-1:0]       root_link_q [2];
  logic                out_valid_q;
  rsp_t                out_q;

  logic [WW-1:0] mem_q [NODE_COUNT];
  logic [WW-1:0] rd_a_q, rd_b_q;
  logic          za_q, zb_q;

  logic          mem_we;
  logic [NW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic [NW-1:0] raddr_a, raddr_b;
  logic          res_load;
  logic          accept;

  logic [NW-1:0]     cw_link [2];
  logic [SIZE_W-1:0] cw_size;
  logic              side;
  logic [NW-1:0]     nxt;
  logic              alloc;
  logic [NW-1:0]     new_id;
  logic [WW-1:0]     cw_word;
  logic [WW-1:0]     ins_word;

  logic [SIZE_W-1:0] sz0, sz1, sz_w;
  logic              want, take_want, go_one, ch_zero;
  logic [WW-1:0]     ch_word;
  logic [NW-1:0]     ch_l0, ch_l1;

  logic ins_refuse, qry_refuse;

  assign accept     = in_valid_i && in_ready_o;
  assign ins_refuse = (nodes_used_q > NODE_LIMIT) || (keys_stored_q == KEYS_MAX);
  assign qry_refuse = (in_data_i.rank == '0) || (in_data_i.rank > keys_stored_q);

  // Record of the node being walked during an insert, with its size already bumped.
  always_comb begin
    if (at_root_q) begin
      cw_link[0] = root_link_q[0];
      cw_link[1] = root_link_q[1];
      cw_size    = '0;
    end else if (fresh_q) begin
      cw_link[0] = '0;
      cw_link[1] = '0;
      cw_size    = SIZE_W'(1);
    end else begin
      cw_link[0] = rd_a_q[SIZE_W +: NW];
      cw_link[1] = rd_a_q[SIZE_W + NW +: NW];
      cw_size    = rd_a_q[SIZE_W-1:0] + SIZE_W'(1);
    end
  end

  assign side    = key_q[lvl_q];
  assign nxt     = cw_link[side];
  assign alloc   = (nxt == '0);
  assign new_id  = nodes_used_q + NW'(1);
  assign cw_word = {cw_link[1], cw_link[0], cw_size};

  always_comb begin
    ins_word = cw_word;
    if (alloc) begin
      if (side) begin
        ins_word[SIZE_W + NW +: NW] = new_id;
      end else begin
        ins_word[SIZE_W +: NW] = new_id;
      end
    end
  end

  assign sz0       = za_q ? '0 : rd_a_q[SIZE_W-1:0];
  assign sz1       = zb_q ? '0 : rd_b_q[SIZE_W-1:0];
  assign want      = ~key_q[lvl_q];
  assign sz_w      = want ? sz1 : sz0;
  assign take_want = (sz_w >= rank_q);
  assign go_one    = take_want ? want : ~want;
  assign ch_word   = go_one ? rd_b_q : rd_a_q;
  assign ch_zero   = go_one ? zb_q : za_q;
  assign ch_l0     = ch_zero ? '0 : ch_word[SIZE_W +: NW];
  assign ch_l1     = ch_zero ? '0 : ch_word[SIZE_W + NW +: NW];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.req_type == REQ_INSERT) begin
            state_d = ins_refuse ? ST_RESP : ST_INS;
          end else begin
            state_d = qry_refuse ? ST_RESP : ST_QRY;
          end
        end
      end
      ST_INS: begin
        if (lvl_q == '0) begin
          state_d = ST_INS_FIN;
        end
      end
      ST_INS_FIN: state_d = ST_RESP;
      ST_QRY: begin
        if (lvl_q == '0) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    waddr      = cur_q;
    wdata      = cw_word;
    raddr_a    = root_link_q[0];
    raddr_b    = root_link_q[1];
    res_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_INS: begin
        mem_we  = !at_root_q;
        wdata   = ins_word;
        raddr_a = nxt;
      end
      ST_INS_FIN: mem_we = 1'b1;
      ST_QRY: begin
        raddr_a = ch_l0;
        raddr_b = ch_l1;
      end
      ST_RESP: res_load = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
    za_q   <= (raddr_a == '0);
    zb_q   <= (raddr_b == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      nodes_used_q   <= '0;
      keys_stored_q  <= '0;
      root_link_q[0] <= '0;
      root_link_q[1] <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INS && alloc) begin
        nodes_used_q <= new_id;
        if (at_root_q) begin
          root_link_q[side] <= new_id;
        end
      end
      if (state_q == ST_INS_FIN) begin
        keys_stored_q <= keys_stored_q + SIZE_W'(1);
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_q     <= in_data_i.key;
          rank_q    <= in_data_i.rank;
          lvl_q     <= LVL_W'(KEY_BITS - 1);
          at_root_q <= 1'b1;
          fresh_q   <= 1'b0;
          acc_q     <= '0;
          if (in_data_i.req_type == REQ_INSERT) begin
            status_q <= ins_refuse ? STATUS_FULL : STATUS_OK;
          end else begin
            status_q <= qry_refuse ? STATUS_BAD_RANK : STATUS_OK;
          end
        end
      end
      ST_INS: begin
        cur_q     <= alloc ? new_id : nxt;
        fresh_q   <= alloc;
        at_root_q <= 1'b0;
        lvl_q     <= lvl_q - LVL_W'(1);
      end
      ST_QRY: begin
        if (take_want) begin
          acc_q[lvl_q] <= 1'b1;
        end else begin
          rank_q <= rank_q - sz_w;
        end
        lvl_q <= lvl_q - LVL_W'(1);
      end
      ST_RESP: begin
        if (res_load) begin
          out_q.xor_value <= acc_q;
          out_q.status    <= status_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `XTKL_ASSERT_IMP(a_nodes_bound, clk_i, rst_ni, 1'b1, nodes_used_q <= NODE_MAX, "node count past memory depth")
  `XTKL_ASSERT_IMP(a_root_not_stored, clk_i, rst_ni, mem_we, waddr != '0, "root record written to memory")
  `XTKL_ASSERT_IMP(a_rw_apart, clk_i, rst_ni, mem_we && state_q == ST_INS, waddr != raddr_a, "insert reads the node it writes")
  `XTKL_ASSERT_NXT(a_out_drains, clk_i, rst_ni, out_valid_o && out_ready_i && !res_load, !out_valid_o, "result beat repeated")

endmodule
